// File: sv/bdq_pkg.sv
package bdq_pkg;

  // Width and reset value of the capacity register
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_PUSH_LEFT  = 2'd0,
    OP_PUSH_RIGHT = 2'd1,
    OP_POP_LEFT   = 2'd2,
    OP_POP_RIGHT  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_PUSHED = 2'd0,
    ST_POPPED = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic take_left;   // load the left neighbor's word (push left)
    logic take_right;  // load the right neighbor's word (pop left)
    logic push_end;    // the cell just past the right end loads the pushed word
  } cell_ctrl_t;

endpackage

// File: sv/bdq_cell.sv
module bdq_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int OCC_W      = 5,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  bdq_pkg::cell_ctrl_t   ctrl,
  input  logic [OCC_W-1:0]      occupancy,
  input  logic [DATA_WIDTH-1:0] push_word,
  input  logic [DATA_WIDTH-1:0] left_word,
  input  logic [DATA_WIDTH-1:0] right_word,
  output logic [DATA_WIDTH-1:0] word,
  output logic [DATA_WIDTH-1:0] tail_word
);

  localparam logic [OCC_W-1:0] MY_POS   = OCC_W'(INDEX);
  localparam logic [OCC_W-1:0] TAIL_POS = OCC_W'(INDEX + 1);

  // Shift with the neighbors, or take the word appended at the right end
  always_ff @(posedge clk) begin
    priority if (ctrl.take_left) begin
      word <= left_word;
    end else if (ctrl.take_right) begin
      word <= right_word;
    end else if (ctrl.push_end && occupancy == MY_POS) begin
      word <= push_word;
    end else begin
      word <= word;
    end
  end

  // Offer the word when this cell holds the rightmost value
  assign tail_word = (occupancy == TAIL_POS) ? word : '0;

endmodule

// File: sv/bounded_double_ended_queue_top.sv
// A result appears in the output register in the cycle after its word is accepted.
// The block takes one word per cycle while results are taken at once; a result that waits in
// the output register holds off the next word. Each operation is at most one shift or load.
// Reset (rst, synchronous, active high): queue empty, capacity 16, no result pending.
// Cell contents are not cleared; only the occupancy count marks which cells hold values.
module bounded_double_ended_queue_top #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bdq_pkg::CAP_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   opcode,
  input  logic signed [31:0]           push_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   status,
  output logic signed [31:0]           value
);

  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (OCC_W > bdq_pkg::CAP_W) ? OCC_W : bdq_pkg::CAP_W;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

  logic [bdq_pkg::CAP_W-1:0] capacity;
  logic [OCC_W-1:0]          occupancy;
  logic [OCC_W-1:0]          occupancy_next;
  logic                      status_valid;
  bdq_pkg::status_t          status_q;
  bdq_pkg::status_t          status_next;
  logic [31:0]               value_q;
  logic [31:0]               value_next;

  bdq_pkg::cell_ctrl_t       ctrl;
  bdq_pkg::opcode_t          op;
  logic                      accept;
  logic                      full;
  logic                      empty;
  logic [CMP_W-1:0]          cap_ext;
  logic [CMP_W-1:0]          limit;
  logic [DATA_WIDTH-1:0]     push_word;
  logic [DATA_WIDTH-1:0]     tail_any;
  logic [DATA_WIDTH-1:0]     words [DEPTH];
  logic [DATA_WIDTH-1:0]     tails [DEPTH];

  // Configuration register; always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= bdq_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // Handshake: take a word whenever the output register is free or draining
  assign in_ready = !status_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign op       = bdq_pkg::opcode_t'(opcode);

  // Saturate the capacity at the number of cells
  assign cap_ext = CMP_W'(capacity);
  assign limit   = (cap_ext > DEPTH_C) ? DEPTH_C : cap_ext;
  assign full    = CMP_W'(occupancy) >= limit;
  assign empty   = occupancy == '0;

  assign push_word = DATA_WIDTH'($unsigned(push_value));

  // Gather the rightmost held value
  always_comb begin
    tail_any = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_any = tail_any | tails[i];
    end
  end

  // Decode the operation into a chain command and a result
  always_comb begin
    ctrl           = '0;
    occupancy_next = occupancy;
    status_next    = bdq_pkg::ST_FULL;
    value_next     = '0;
    unique case (op)
      bdq_pkg::OP_PUSH_LEFT, bdq_pkg::OP_PUSH_RIGHT: begin
        if (full) begin
          status_next = bdq_pkg::ST_FULL;
        end else begin
          status_next    = bdq_pkg::ST_PUSHED;
          value_next     = 32'(push_word);
          occupancy_next = occupancy + OCC_W'(1);
          ctrl.take_left = accept && (op == bdq_pkg::OP_PUSH_LEFT);
          ctrl.push_end  = accept && (op == bdq_pkg::OP_PUSH_RIGHT);
        end
      end
      bdq_pkg::OP_POP_LEFT, bdq_pkg::OP_POP_RIGHT: begin
        if (empty) begin
          status_next = bdq_pkg::ST_EMPTY;
        end else begin
          status_next     = bdq_pkg::ST_POPPED;
          value_next      = (op == bdq_pkg::OP_POP_LEFT) ? 32'(words[0]) : 32'(tail_any);
          occupancy_next  = occupancy - OCC_W'(1);
          ctrl.take_right = accept && (op == bdq_pkg::OP_POP_LEFT);
        end
      end
      default: begin
        status_next = bdq_pkg::ST_FULL;
      end
    endcase
  end

  // Advance the occupancy count
  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (accept) begin
      occupancy <= occupancy_next;
    end
  end

  // Output register: hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      status_valid <= 1'b0;
    end else if (accept) begin
      status_valid <= 1'b1;
    end else if (out_ready) begin
      status_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_q <= status_next;
      value_q  <= value_next;
    end
  end

  assign out_valid = status_valid;
  assign status    = status_q;
  assign value     = value_q;

  // Chain of cells, leftmost value in cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_word;
    logic [DATA_WIDTH-1:0] right_word;

    if (i == 0) begin : g_first
      assign left_word = push_word;
    end else begin : g_mid_l
      assign left_word = words[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_word = '0;
    end else begin : g_mid_r
      assign right_word = words[i+1];
    end

    bdq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .OCC_W      (OCC_W),
      .INDEX      (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupancy  (occupancy),
      .push_word  (push_word),
      .left_word  (left_word),
      .right_word (right_word),
      .word       (words[i]),
      .tail_word  (tails[i])
    );
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(occupancy) <= DEPTH_C)
    else $error("occupancy beyond cell count");

  a_refused_holds: assert property (@(posedge clk) disable iff (rst)
    accept && (status_next == bdq_pkg::ST_FULL || status_next == bdq_pkg::ST_EMPTY)
    |=> $stable(occupancy))
    else $error("refused word changed occupancy");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    accept && status_next == bdq_pkg::ST_PUSHED |=> occupancy == $past(occupancy) + OCC_W'(1))
    else $error("push did not grow occupancy");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    accept && status_next == bdq_pkg::ST_POPPED |=> occupancy == $past(occupancy) - OCC_W'(1))
    else $error("pop did not shrink occupancy");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status_q == bdq_pkg::ST_FULL || status_q == bdq_pkg::ST_EMPTY)
    |-> value_q == '0)
    else $error("refused result carries a value");
`endif

endmodule

// File: tb/bounded_double_ended_queue_top_tb.sv
`timescale 1ns / 100ps

module bounded_double_ended_queue_top_tb;

  localparam int QUEUE_DEPTH = 16;

  typedef struct {
    bdq_pkg::opcode_t op;
    logic [31:0]      word;
  } deque_cmd_t;

  typedef struct {
    bdq_pkg::status_t st;
    logic [31:0]      val;
  } deque_result_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [bdq_pkg::CAP_W-1:0]   cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [1:0]                  opcode = '0;
  logic signed [31:0]          push_value = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [1:0]                  status;
  logic signed [31:0]          value;

  // Words waiting to be offered, and results the deque still owes
  deque_cmd_t    cmd_backlog[$];
  deque_result_t due_results[$];

  // Shadow of the deque state
  logic [31:0]               shadow_cells[QUEUE_DEPTH];
  logic [3:0]                shadow_left = '0;
  int unsigned               shadow_held = 0;
  logic [bdq_pkg::CAP_W-1:0] shadow_cap = bdq_pkg::CAP_RESET;

  logic in_taken = 1'b0;
  logic cfg_taken = 1'b0;
  int   mismatch_count = 0;
  int   results_seen = 0;

  // Sender pacing
  int gap_left = 0;
  int burst_left = 0;

  // Receiver pacing
  int ready_mode = 0;
  int pattern_left = 0;
  int pattern_phase = 0;
  int hold_left = 0;
  int holds_done = 0;

  bounded_double_ended_queue_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .push_value (push_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .value      (value)
  );

  always #5 clk = ~clk;

  // Apply one operation to the shadow deque and return the result it owes
  function automatic deque_result_t predict_deque_result(input bdq_pkg::opcode_t op,
                                                         input logic [31:0] word);
    deque_result_t r;
    int unsigned   lim;
    logic [3:0]    slot;
    r.st = bdq_pkg::ST_PUSHED;
    r.val = '0;
    lim = (shadow_cap > QUEUE_DEPTH) ? QUEUE_DEPTH : shadow_cap;
    if (op == bdq_pkg::OP_PUSH_LEFT || op == bdq_pkg::OP_PUSH_RIGHT) begin
      if (shadow_held >= lim) begin
        r.st = bdq_pkg::ST_FULL;
      end else begin
        if (op == bdq_pkg::OP_PUSH_LEFT) begin
          shadow_left = shadow_left - 4'd1;
          slot = shadow_left;
        end else begin
          slot = shadow_left + 4'(shadow_held);
        end
        shadow_cells[slot] = word;
        shadow_held++;
        r.val = word;
      end
    end else begin
      if (shadow_held == 0) begin
        r.st = bdq_pkg::ST_EMPTY;
      end else begin
        if (op == bdq_pkg::OP_POP_LEFT) begin
          slot = shadow_left;
          shadow_left = shadow_left + 4'd1;
        end else begin
          slot = shadow_left + 4'(shadow_held) - 4'd1;
        end
        r.st = bdq_pkg::ST_POPPED;
        r.val = shadow_cells[slot];
        shadow_held--;
      end
    end
    return r;
  endfunction

  // Offer words from the backlog in bursts separated by random gaps
  always @(negedge clk) begin
    deque_cmd_t cmd;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold the offered word until it is taken
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (cmd_backlog.size() != 0) begin
      cmd = cmd_backlog.pop_front();
      in_valid <= 1'b1;
      opcode <= cmd.op;
      push_value <= cmd.word;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 40);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Stall the result side on shifting patterns, with two long hold-offs
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (holds_done < 2 && results_seen >= 400 + holds_done * 900 && in_valid) begin
      hold_left = 150;
      holds_done++;
      out_ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        pattern_left = $urandom_range(20, 100);
      end
      pattern_left--;
      pattern_phase++;
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (pattern_phase % 3 != 0);
      endcase
    end
  end

  // Track handshakes, check results, and predict each accepted word
  always @(posedge clk) begin
    deque_result_t want;
    if (rst) begin
      in_taken <= 1'b0;
      cfg_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      cfg_taken <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready)
        shadow_cap = cfg_data;
      if (out_valid && out_ready) begin
        results_seen++;
        if (due_results.size() == 0) begin
          $error("unexpected result: status %0d value %h", status, value);
          mismatch_count++;
        end else begin
          want = due_results.pop_front();
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            mismatch_count++;
          end
          if (value !== want.val) begin
            $error("value: expected %h, got %h", want.val, value);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready)
        due_results.push_back(predict_deque_result(bdq_pkg::opcode_t'(opcode), push_value));
    end
  end

  task automatic queue_cmd(input bdq_pkg::opcode_t op, input logic [31:0] word);
    deque_cmd_t cmd;
    cmd.op = op;
    cmd.word = word;
    cmd_backlog.push_back(cmd);
  endtask

  // Wait until every word is taken and every result has come back
  task automatic drain();
    while (cmd_backlog.size() != 0 || in_valid || due_results.size() != 0)
      @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [bdq_pkg::CAP_W-1:0] cap);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Queue random words, with the push share drifting so the deque fills and empties
  task automatic queue_random(input int count);
    int push_pct;
    int run_left;
    push_pct = 50;
    run_left = 0;
    repeat (count) begin
      if (run_left == 0) begin
        case ($urandom_range(0, 3))
          0: push_pct = 15;
          1: push_pct = 50;
          2: push_pct = 85;
          default: push_pct = 100;
        endcase
        run_left = $urandom_range(16, 48);
      end
      run_left--;
      if ($urandom_range(0, 99) < push_pct)
        queue_cmd($urandom_range(0, 1) ? bdq_pkg::OP_PUSH_RIGHT : bdq_pkg::OP_PUSH_LEFT,
                  random_word());
      else
        queue_cmd($urandom_range(0, 1) ? bdq_pkg::OP_POP_RIGHT : bdq_pkg::OP_POP_LEFT,
                  random_word());
    end
  endtask

  initial begin
    logic [bdq_pkg::CAP_W-1:0] caps[12];
    caps = '{5'd31, 5'd1, 5'd16, 5'd0, 5'd17, 5'd7, 5'd3, 5'd24, 5'd12, 5'd2, 5'd16, 5'd0};
    caps[11] = bdq_pkg::CAP_W'($urandom_range(0, 31));

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);

    // Empty pops, extreme values on both ends, pops from both ends at reset capacity
    queue_cmd(bdq_pkg::OP_POP_LEFT, $urandom);
    queue_cmd(bdq_pkg::OP_POP_RIGHT, $urandom);
    queue_cmd(bdq_pkg::OP_PUSH_LEFT, 32'h7FFF_FFFF);
    queue_cmd(bdq_pkg::OP_PUSH_RIGHT, 32'h8000_0000);
    queue_cmd(bdq_pkg::OP_PUSH_LEFT, 32'hFFFF_FFFF);
    queue_cmd(bdq_pkg::OP_PUSH_RIGHT, 32'h0000_0000);
    queue_cmd(bdq_pkg::OP_POP_RIGHT, $urandom);
    queue_cmd(bdq_pkg::OP_POP_LEFT, $urandom);
    queue_cmd(bdq_pkg::OP_POP_RIGHT, $urandom);
    queue_cmd(bdq_pkg::OP_POP_LEFT, $urandom);

    // Small capacity: refuse pushes on both ends once full
    write_capacity(5'd2);
    queue_cmd(bdq_pkg::OP_PUSH_RIGHT, 32'h5555_5555);
    queue_cmd(bdq_pkg::OP_PUSH_LEFT, 32'hAAAA_AAAA);
    queue_cmd(bdq_pkg::OP_PUSH_RIGHT, 32'h0000_0001);
    queue_cmd(bdq_pkg::OP_PUSH_LEFT, 32'h0000_0001);
    queue_cmd(bdq_pkg::OP_POP_RIGHT, $urandom);
    queue_cmd(bdq_pkg::OP_POP_LEFT, $urandom);

    // Zero capacity refuses every push
    write_capacity(5'd0);
    queue_cmd(bdq_pkg::OP_PUSH_LEFT, $urandom);
    queue_cmd(bdq_pkg::OP_PUSH_RIGHT, $urandom);
    queue_cmd(bdq_pkg::OP_POP_LEFT, $urandom);

    // Capacity above the store saturates; then lower it below the occupancy
    write_capacity(5'd17);
    queue_cmd(bdq_pkg::OP_PUSH_LEFT, $urandom);
    queue_cmd(bdq_pkg::OP_PUSH_RIGHT, $urandom);
    queue_cmd(bdq_pkg::OP_PUSH_RIGHT, $urandom);
    write_capacity(5'd1);
    queue_cmd(bdq_pkg::OP_PUSH_LEFT, $urandom);
    queue_cmd(bdq_pkg::OP_POP_LEFT, $urandom);
    queue_cmd(bdq_pkg::OP_POP_RIGHT, $urandom);
    queue_cmd(bdq_pkg::OP_PUSH_RIGHT, $urandom);
    queue_cmd(bdq_pkg::OP_POP_LEFT, $urandom);

    // Random phases; the deque keeps its contents across capacity changes
    foreach (caps[i]) begin
      write_capacity(caps[i]);
      queue_random(158);
    end
    drain();

    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
